// File: design/rtqh_pkg.sv
// Shared widths, constants and control types of the ray / face hit test.
`timescale 1ns / 1ps
`default_nettype none
package rtqh_pkg;

	// Point and coordinate widths
	localparam int COORD_W   = 32;
	localparam int PT_W      = 3 * COORD_W;
	localparam int PT_DEPTH  = 6;
	localparam int PT_IDX_W  = 3;
	localparam int MODE_W    = 3;
	localparam int CNT_W     = 3;

	// Arithmetic widths: edge difference, cross product, dot product
	localparam int DIFF_W    = COORD_W + 1;
	localparam int CROSS_W   = 2 * DIFF_W + 1;
	localparam int LO_W      = (CROSS_W + 1) / 2;
	localparam int OPW       = LO_W + 1;
	localparam int PROD_W    = 2 * OPW;
	localparam int ACC_W     = DIFF_W + CROSS_W + 2;

	// Determinant threshold register
	localparam int EPS_W     = 40;
	localparam logic [EPS_W-1:0] EPS_RESET = 40'd281474977;
	localparam int EPS_POINT = 48;
	localparam int FRAC_BITS_DEF = 16;

	// Operand file layout
	localparam int OPF_DEPTH = 24;
	localparam int ADDR_W    = 5;
	localparam logic [ADDR_W-1:0] A_RAY   = 5'd0;
	localparam logic [ADDR_W-1:0] A_E1    = 5'd3;
	localparam logic [ADDR_W-1:0] A_E2    = 5'd6;
	localparam logic [ADDR_W-1:0] A_TV    = 5'd9;
	localparam logic [ADDR_W-1:0] A_PV_LO = 5'd12;
	localparam logic [ADDR_W-1:0] A_PV_HI = 5'd15;
	localparam logic [ADDR_W-1:0] A_QV_LO = 5'd18;
	localparam logic [ADDR_W-1:0] A_QV_HI = 5'd21;

	// Point slots
	localparam logic [PT_IDX_W-1:0] PT_C0    = 3'd0;
	localparam logic [PT_IDX_W-1:0] PT_C1    = 3'd1;
	localparam logic [PT_IDX_W-1:0] PT_C2    = 3'd2;
	localparam logic [PT_IDX_W-1:0] PT_C3    = 3'd3;
	localparam logic [PT_IDX_W-1:0] PT_START = 3'd4;
	localparam logic [PT_IDX_W-1:0] PT_END   = 3'd5;
	localparam logic [MODE_W-1:0]   MODE_LAST = 3'd5;

	// Corner counts
	localparam logic [CNT_W-1:0] CNT_TRI  = 3'd3;
	localparam logic [CNT_W-1:0] CNT_QUAD = 3'd4;

	// Pipe depth from operand read to accumulator
	localparam logic [1:0] DRAIN_CYC = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_CROSS,
		ST_DOT,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CHK_NONE,
		CHK_NORM,
		CHK_CMP,
		CHK_FIN
	} chk_t;

	typedef enum logic [1:0] {
		SV_DET,
		SV_UN,
		SV_VN,
		SV_TN
	} save_sel_t;

	// One micro-operation from the sequencer
	typedef struct packed {
		logic                 pread;
		logic [PT_IDX_W-1:0]  pf_sel;
		logic [PT_IDX_W-1:0]  pt_sel;
		logic                 dsub;
		logic [1:0]           comp;
		logic                 wr_lo;
		logic                 wr_hi;
		logic [ADDR_W-1:0]    waddr;
		logic                 mac;
		logic [ADDR_W-1:0]    ra;
		logic [ADDR_W-1:0]    rb;
		logic                 clr;
		logic                 neg;
		logic                 hi;
		logic                 save;
		save_sel_t            save_sel;
		chk_t                 chk;
		logic                 clr_hit;
	} uop_t;

	// Multiply-accumulate control carried down the pipe
	typedef struct packed {
		logic mac;
		logic clr;
		logic neg;
		logic hi;
	} mac_ctl_t;

	// Next index modulo three
	function automatic logic [1:0] next3(input logic [1:0] c);
		next3 = (c == 2'd2) ? 2'd0 : c + 2'd1;
	endfunction

endpackage
`default_nettype wire

// File: design/rtqh_if.sv
// Channel interfaces: point items in, hit items out, threshold writes.
`timescale 1ns / 1ps
`default_nettype none
interface rtqh_in_if import rtqh_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic signed [COORD_W-1:0]  coord_z;
	logic [CNT_W-1:0]           corner_count;
	logic                       evaluate;

	modport source (output valid, mode, coord_x, coord_y, coord_z, corner_count, evaluate,
		input ready);
	modport sink (input valid, mode, coord_x, coord_y, coord_z, corner_count, evaluate,
		output ready);
endinterface

interface rtqh_out_if ();
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

interface rtqh_cfg_if import rtqh_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EPS_W-1:0]   det_epsilon;

	modport source (output valid, det_epsilon, input ready);
	modport sink (input valid, det_epsilon, output ready);
endinterface
`default_nettype wire

// File: design/rtqh_pstore.sv
// Point store: six points, one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module rtqh_pstore import rtqh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [PT_IDX_W-1:0]  wr_idx,
	input  logic [PT_W-1:0]      wr_data,
	input  uop_t                 uop,
	output logic [PT_W-1:0]      p_from,
	output logic [PT_W-1:0]      p_to
);

	logic [PT_W-1:0]     mem [PT_DEPTH];
	logic [PT_DEPTH-1:0] valid_q;
	logic [PT_W-1:0]     from_q;
	logic [PT_W-1:0]     to_q;

	// Written slots; an unwritten slot reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// Both ends of one difference vector
	always_ff @(posedge clk) begin
		if (uop.pread) begin
			from_q <= valid_q[uop.pf_sel] ? mem[uop.pf_sel] : '0;
			to_q   <= valid_q[uop.pt_sel] ? mem[uop.pt_sel] : '0;
		end
	end

	assign p_from = from_q;
	assign p_to   = to_q;

endmodule
`default_nettype wire

// File: design/rtqh_mac.sv
// Operand file, edge subtractor and the shared multiply-accumulate unit.
`timescale 1ns / 1ps
`default_nettype none
module rtqh_mac import rtqh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  uop_t                     uop,
	input  logic [PT_W-1:0]          p_from,
	input  logic [PT_W-1:0]          p_to,
	output logic signed [ACC_W-1:0]  acc
);

	logic signed [OPW-1:0]     opf_mem [OPF_DEPTH];
	logic signed [OPW-1:0]     rda_s1;
	logic signed [OPW-1:0]     rdb_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	mac_ctl_t                  ctl_s1;
	mac_ctl_t                  ctl_s2;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [COORD_W-1:0] from_c;
	logic signed [COORD_W-1:0] to_c;
	logic signed [DIFF_W-1:0]  diff;
	logic                      we;
	logic signed [OPW-1:0]     wdata;
	logic signed [ACC_W-1:0]   term;
	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   base;

	// Coordinate pick and edge difference
	always_comb begin
		case (uop.comp)
			2'd0: begin
				from_c = p_from[0*COORD_W +: COORD_W];
				to_c   = p_to[0*COORD_W +: COORD_W];
			end
			2'd1: begin
				from_c = p_from[1*COORD_W +: COORD_W];
				to_c   = p_to[1*COORD_W +: COORD_W];
			end
			default: begin
				from_c = p_from[2*COORD_W +: COORD_W];
				to_c   = p_to[2*COORD_W +: COORD_W];
			end
		endcase
		diff = DIFF_W'(to_c) - DIFF_W'(from_c);
	end

	// Operand file write: edge component or one half of a cross product
	always_comb begin
		we    = uop.dsub | uop.wr_lo | uop.wr_hi;
		wdata = OPW'(diff);
		if (uop.wr_lo) begin
			wdata = $signed({1'b0, acc_q[LO_W-1:0]});
		end else if (uop.wr_hi) begin
			wdata = OPW'($signed(acc_q[CROSS_W-1:LO_W]));
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			opf_mem[uop.waddr] <= wdata;
		end
	end

	// Stage 1: operand reads
	always_ff @(posedge clk) begin
		if (uop.mac) begin
			rda_s1 <= opf_mem[uop.ra];
			rdb_s1 <= opf_mem[uop.rb];
		end
	end

	// Stage 2: product
	always_ff @(posedge clk) begin
		prod_s2 <= rda_s1 * rdb_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= '{mac: uop.mac, clr: uop.clr, neg: uop.neg, hi: uop.hi};
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage 3: accumulate, high half weighted by 2^LO_W, optional subtract
	always_comb begin
		term   = ctl_s2.hi ? (ACC_W'(prod_s2) <<< LO_W) : ACC_W'(prod_s2);
		addend = term ^ {ACC_W{ctl_s2.neg}};
		base   = ctl_s2.clr ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.mac) begin
			acc_q <= base + addend + $signed({{(ACC_W-1){1'b0}}, ctl_s2.neg});
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// File: design/rtqh_judge.sv
// Saved dot products, sign-aware bound checks and the face hit flag.
`timescale 1ns / 1ps
`default_nettype none
module rtqh_judge import rtqh_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  uop_t                     uop,
	input  logic signed [ACC_W-1:0]  acc,
	input  logic [EPS_W-1:0]         eps,
	output logic                     hit
);

	// Threshold scale: |det| * 2^EPS_POINT against eps * 2^(3*FRAC_BITS)
	localparam int SHL3    = 3 * FRAC_BITS;
	localparam int DET_SHL = (SHL3 < EPS_POINT) ? EPS_POINT - SHL3 : 0;
	localparam int EPS_SHL = (SHL3 > EPS_POINT) ? SHL3 - EPS_POINT : 0;
	localparam int CMP_L   = ACC_W + DET_SHL;
	localparam int CMP_R   = EPS_W + EPS_SHL;
	localparam int CMP_W   = ((CMP_L > CMP_R) ? CMP_L : CMP_R) + 1;

	logic signed [ACC_W-1:0] d_q;
	logic signed [ACC_W-1:0] u_q;
	logic signed [ACC_W-1:0] v_q;
	logic signed [ACC_W-1:0] t_q;
	logic signed [ACC_W:0]   sum_q;
	logic                    fail_q;
	logic                    hit_q;

	logic [CMP_W-1:0]        det_mag;
	logic [CMP_W-1:0]        eps_mag;
	logic                    near_zero;
	logic                    u_bad;
	logic                    tri_ok;

	always_comb begin
		det_mag   = CMP_W'($unsigned(d_q)) << DET_SHL;
		eps_mag   = CMP_W'(eps) << EPS_SHL;
		near_zero = (det_mag < eps_mag) || (d_q == '0);
		u_bad     = u_q[ACC_W-1] || (d_q < u_q);
		tri_ok    = !fail_q && !($signed({d_q[ACC_W-1], d_q}) < sum_q) && !t_q[ACC_W-1];
	end

	// Save, normalize by the sign of det, then compare
	always_ff @(posedge clk) begin
		if (uop.save) begin
			case (uop.save_sel)
				SV_DET:  d_q <= acc;
				SV_UN:   u_q <= acc;
				SV_VN:   v_q <= acc;
				default: t_q <= acc;
			endcase
		end else if (uop.chk == CHK_NORM && d_q[ACC_W-1]) begin
			d_q <= -d_q;
			u_q <= -u_q;
			v_q <= -v_q;
			t_q <= -t_q;
		end
		if (uop.chk == CHK_CMP) begin
			sum_q  <= (ACC_W+1)'(u_q) + (ACC_W+1)'(v_q);
			fail_q <= near_zero | u_bad | v_q[ACC_W-1];
		end
	end

	// Hit flag: OR over the triangles of one face
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (uop.clr_hit) begin
			hit_q <= 1'b0;
		end else if (uop.chk == CHK_FIN) begin
			hit_q <= hit_q | tri_ok;
		end
	end

	assign hit = hit_q;

endmodule
`default_nettype wire

// File: design/rtqh_seq.sv
// Sequencer: steps the shared unit through edges, crosses, dots and checks.
`timescale 1ns / 1ps
`default_nettype none
module rtqh_seq import rtqh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  count,
	input  logic              slot_free,
	output logic              idle,
	output logic              finish,
	output uop_t              uop
);

	state_t      state_q, state_d;
	logic [1:0]  grp_q, grp_d;
	logic [2:0]  sub_q, sub_d;
	logic [1:0]  comp_q, comp_d;
	logic        tri_q, tri_d;
	logic        quad_q, quad_d;
	logic [1:0]  wait_q, wait_d;

	logic [PT_IDX_W-1:0] pa;
	logic [PT_IDX_W-1:0] pb;
	logic [PT_IDX_W-1:0] pc;
	logic [1:0]          cj;
	logic [1:0]          ck;
	logic [1:0]          dcomp;
	logic [ADDR_W-1:0]   abase;
	logic [ADDR_W-1:0]   bbase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grp_q   <= '0;
			sub_q   <= '0;
			comp_q  <= '0;
			tri_q   <= 1'b0;
			quad_q  <= 1'b0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			grp_q   <= grp_d;
			sub_q   <= sub_d;
			comp_q  <= comp_d;
			tri_q   <= tri_d;
			quad_q  <= quad_d;
			wait_q  <= wait_d;
		end
	end

	// Corners of the current triangle: (0,1,2) then (2,3,0)
	always_comb begin
		pa    = tri_q ? PT_C2 : PT_C0;
		pb    = tri_q ? PT_C3 : PT_C1;
		pc    = tri_q ? PT_C0 : PT_C2;
		cj    = next3(comp_q);
		ck    = next3(cj);
		dcomp = sub_q[2:1];
	end

	always_comb begin
		state_d = state_q;
		grp_d   = grp_q;
		sub_d   = sub_q;
		comp_d  = comp_q;
		tri_d   = tri_q;
		quad_d  = quad_q;
		wait_d  = wait_q;
		uop     = '0;
		finish  = 1'b0;
		abase   = A_RAY;
		bbase   = A_E2;

		if (wait_q != 2'd0) begin
			// let the last product reach the accumulator
			wait_d = wait_q - 2'd1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						uop.clr_hit = 1'b1;
						tri_d  = 1'b0;
						grp_d  = '0;
						sub_d  = '0;
						comp_d = '0;
						quad_d = (count == CNT_QUAD);
						if (count == CNT_TRI || count == CNT_QUAD) begin
							state_d = ST_DIFF;
						end else begin
							state_d = ST_DONE;
						end
					end
				end

				// ray, e1, e2, tv: point read then three subtracts each
				ST_DIFF: begin
					case (grp_q)
						2'd0: begin
							uop.pf_sel = PT_START;
							uop.pt_sel = PT_END;
							abase      = A_RAY;
						end
						2'd1: begin
							uop.pf_sel = pa;
							uop.pt_sel = pb;
							abase      = A_E1;
						end
						2'd2: begin
							uop.pf_sel = pa;
							uop.pt_sel = pc;
							abase      = A_E2;
						end
						default: begin
							uop.pf_sel = pa;
							uop.pt_sel = PT_START;
							abase      = A_TV;
						end
					endcase
					if (sub_q == 3'd0) begin
						uop.pread = 1'b1;
					end else begin
						uop.dsub  = 1'b1;
						uop.comp  = sub_q[1:0] - 2'd1;
						uop.waddr = abase + ADDR_W'(uop.comp);
					end
					if (sub_q == 3'd3) begin
						sub_d = '0;
						if (grp_q == 2'd3) begin
							grp_d   = '0;
							comp_d  = '0;
							state_d = ST_CROSS;
						end else begin
							grp_d = grp_q + 2'd1;
						end
					end else begin
						sub_d = sub_q + 3'd1;
					end
				end

				// pv = ray x e2, qv = tv x e1, stored as low and high halves
				ST_CROSS: begin
					abase = (grp_q == 2'd0) ? A_RAY : A_TV;
					bbase = (grp_q == 2'd0) ? A_E2 : A_E1;
					case (sub_q)
						3'd0: begin
							uop.mac = 1'b1;
							uop.clr = 1'b1;
							uop.ra  = abase + ADDR_W'(cj);
							uop.rb  = bbase + ADDR_W'(ck);
						end
						3'd1: begin
							uop.mac = 1'b1;
							uop.neg = 1'b1;
							uop.ra  = abase + ADDR_W'(ck);
							uop.rb  = bbase + ADDR_W'(cj);
							wait_d  = DRAIN_CYC;
						end
						3'd2: begin
							uop.wr_lo = 1'b1;
							uop.waddr = ((grp_q == 2'd0) ? A_PV_LO : A_QV_LO) + ADDR_W'(comp_q);
						end
						default: begin
							uop.wr_hi = 1'b1;
							uop.waddr = ((grp_q == 2'd0) ? A_PV_HI : A_QV_HI) + ADDR_W'(comp_q);
						end
					endcase
					if (sub_q == 3'd3) begin
						sub_d = '0;
						if (comp_q == 2'd2) begin
							comp_d = '0;
							if (grp_q == 2'd1) begin
								grp_d   = '0;
								state_d = ST_DOT;
							end else begin
								grp_d = grp_q + 2'd1;
							end
						end else begin
							comp_d = comp_q + 2'd1;
						end
					end else begin
						sub_d = sub_q + 3'd1;
					end
				end

				// det = e1.pv, u = tv.pv, v = ray.qv, t = e2.qv
				ST_DOT: begin
					case (grp_q)
						2'd0: begin
							abase = A_E1;
							bbase = sub_q[0] ? A_PV_HI : A_PV_LO;
						end
						2'd1: begin
							abase = A_TV;
							bbase = sub_q[0] ? A_PV_HI : A_PV_LO;
						end
						2'd2: begin
							abase = A_RAY;
							bbase = sub_q[0] ? A_QV_HI : A_QV_LO;
						end
						default: begin
							abase = A_E2;
							bbase = sub_q[0] ? A_QV_HI : A_QV_LO;
						end
					endcase
					if (sub_q == 3'd6) begin
						uop.save     = 1'b1;
						uop.save_sel = save_sel_t'(grp_q);
						sub_d        = '0;
						if (grp_q == 2'd3) begin
							grp_d   = '0;
							state_d = ST_CHECK;
						end else begin
							grp_d = grp_q + 2'd1;
						end
					end else begin
						uop.mac = 1'b1;
						uop.clr = (sub_q == 3'd0);
						uop.hi  = sub_q[0];
						uop.ra  = abase + ADDR_W'(dcomp);
						uop.rb  = bbase + ADDR_W'(dcomp);
						if (sub_q == 3'd5) begin
							wait_d = DRAIN_CYC;
						end
						sub_d = sub_q + 3'd1;
					end
				end

				ST_CHECK: begin
					case (sub_q)
						3'd0:    uop.chk = CHK_NORM;
						3'd1:    uop.chk = CHK_CMP;
						default: uop.chk = CHK_FIN;
					endcase
					if (sub_q == 3'd2) begin
						sub_d = '0;
						if (quad_q && !tri_q) begin
							tri_d   = 1'b1;
							state_d = ST_DIFF;
						end else begin
							state_d = ST_DONE;
						end
					end else begin
						sub_d = sub_q + 3'd1;
					end
				end

				ST_DONE: begin
					finish = slot_free;
					if (slot_free) begin
						state_d = ST_IDLE;
					end
				end

				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);

endmodule
`default_nettype wire

// File: design/ray_triangle_quad_hit_test.sv
// Top level of the ray / triangle or quad hit test.
`timescale 1ns / 1ps
`default_nettype none
// A point item with mode 0-5 writes one of six slots (corners 0-3, ray start,
// ray end); items are taken only while the block is idle. An item with
// evaluate set starts the Moller-Trumbore test on the stored points; the
// block then holds ready low until the test is over. A quad runs the
// triangle test twice; a bad corner count gives a miss without running the
// test. An earlier result that is still unread holds the finished test until
// the output register frees up. The time is set by the single 35x35
// multiply-accumulate unit: 36 products per triangle, with a drain of the
// product pipe before each cross-product component is written back and
// before each dot product is saved. The result sits in an output register,
// so load items are taken while it waits. det_epsilon may be written
// whenever the block is idle.
module ray_triangle_quad_hit_test import rtqh_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	rtqh_in_if.sink        point,
	rtqh_out_if.source     result,
	rtqh_cfg_if.sink       cfg
);

	logic                     accept;
	logic                     idle;
	logic                     finish;
	logic                     slot_free;
	logic                     face_hit;
	uop_t                     uop;
	logic [PT_W-1:0]          p_from;
	logic [PT_W-1:0]          p_to;
	logic signed [ACC_W-1:0]  acc;
	logic [EPS_W-1:0]         eps_q;
	logic                     out_valid_q;
	logic                     out_hit_q;

	assign point.ready = idle;
	assign accept      = point.valid & point.ready;
	assign cfg.ready   = 1'b1;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg.valid) begin
			eps_q <= cfg.det_epsilon;
		end
	end

	rtqh_pstore u_pstore (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && (point.mode <= MODE_LAST)),
		.wr_idx  (point.mode),
		.wr_data ({point.coord_z, point.coord_y, point.coord_x}),
		.uop     (uop),
		.p_from  (p_from),
		.p_to    (p_to)
	);

	rtqh_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && point.evaluate),
		.count     (point.corner_count),
		.slot_free (slot_free),
		.idle      (idle),
		.finish    (finish),
		.uop       (uop)
	);

	rtqh_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.uop    (uop),
		.p_from (p_from),
		.p_to   (p_to),
		.acc    (acc)
	);

	rtqh_judge #(
		.FRAC_BITS (FRAC_BITS)
	) u_judge (
		.clk    (clk),
		.arst_n (arst_n),
		.uop    (uop),
		.acc    (acc),
		.eps    (eps_q),
		.hit    (face_hit)
	);

	// Output register
	assign slot_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_hit_q <= face_hit;
		end
	end

	assign result.valid = out_valid_q;
	assign result.hit   = out_hit_q;

endmodule
`default_nettype wire
